### rtl/single_wire_humidity_temp_receiver_top_defines.svh
// assertion macros for the receiver top level rtl
// every check samples on the rising clock edge and is held off during reset
`ifndef SINGLE_WIRE_HUMIDITY_TEMP_RECEIVER_TOP_DEFINES_SVH
`define SINGLE_WIRE_HUMIDITY_TEMP_RECEIVER_TOP_DEFINES_SVH

// same-cycle implication
`define SWHTR_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SWHTR_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/swhtr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swhtr_pkg
// shared types and constants of the single-wire humidity and temperature
// receiver
// ----------------------------------------------------------------------------
package swhtr_pkg;

    // frame layout
    localparam int BITS_PER_FRAME   = 40;
    localparam int FIRST_DATA_PHASE = 4;
    localparam int MAX_PHASES_DEF   = 85;

    // configuration register indexes
    localparam logic [1:0] CFG_ONE_BIT_THRESHOLD = 2'd0;
    localparam logic [1:0] CFG_TIMEOUT_SAMPLES   = 2'd1;
    localparam logic [1:0] CFG_FAN_ON_ABOVE      = 2'd2;
    localparam logic [1:0] CFG_FAN_OFF_BELOW     = 2'd3;

    // configuration reset values
    localparam logic [7:0]         THRESHOLD_RST    = 8'd16;
    localparam logic [7:0]         TIMEOUT_RST      = 8'd255;
    localparam logic signed [15:0] FAN_ON_ABOVE_RST = 16'sd200;
    localparam logic signed [15:0] FAN_OFF_BELOW_RST = 16'sd150;

    // finished frame handed to the decoder, byte 0 in the top bits
    typedef struct packed {
        logic [BITS_PER_FRAME-1:0] bits;
        logic [5:0]                count;
    } frame_t;

    // one decoded result
    typedef struct packed {
        logic [15:0]        humidity_tenths;
        logic signed [15:0] temperature_tenths;
        logic               data_good;
        logic [5:0]         bits_received;
        logic               fan_drive;
    } result_t;

endpackage

### rtl/swhtr_decode.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swhtr_decode
// checksum check, humidity and temperature decode and fan hysteresis for one
// finished frame
// ----------------------------------------------------------------------------
module swhtr_decode
(
    input  swhtr_pkg::frame_t  frame,
    input  logic signed [15:0] fan_on_above,
    input  logic signed [15:0] fan_off_below,
    input  logic               fan_state,
    output swhtr_pkg::result_t result
);

    logic [7:0]         byte0;
    logic [7:0]         byte1;
    logic [7:0]         byte2;
    logic [7:0]         byte3;
    logic [7:0]         byte4;
    logic [9:0]         sum_full;
    logic               good;
    logic [15:0]        magnitude;
    logic signed [15:0] temp;

    // split the received bits into bytes, first byte in the top bits
    assign byte0 = frame.bits[39:32];
    assign byte1 = frame.bits[31:24];
    assign byte2 = frame.bits[23:16];
    assign byte3 = frame.bits[15:8];
    assign byte4 = frame.bits[7:0];

    // checksum over the first four bytes, kept to 8 bits
    assign sum_full = 10'(byte0) + 10'(byte1) + 10'(byte2) + 10'(byte3);
    assign good = (frame.count >= 6'(swhtr_pkg::BITS_PER_FRAME))
                  && (byte4 == sum_full[7:0]);

    // sign and magnitude temperature
    assign magnitude = {1'b0, byte2[6:0], byte3};
    assign temp = byte2[7] ? $signed(16'd0 - magnitude) : $signed(magnitude);

    // result fields and fan hysteresis
    always_comb
    begin
        result.humidity_tenths    = good ? {byte0, byte1} : 16'd0;
        result.temperature_tenths = good ? temp : 16'sd0;
        result.data_good          = good;
        result.bits_received      = frame.count;
        result.fan_drive          = fan_state;
        if (good)
        begin
            if (temp > fan_on_above)
            begin
                result.fan_drive = 1'b1;
            end
            else if (temp < fan_off_below)
            begin
                result.fan_drive = 1'b0;
            end
        end
    end

endmodule

### rtl/single_wire_humidity_temp_receiver_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// single_wire_humidity_temp_receiver_top
// decodes frames of a single-wire humidity and temperature sensor from one
// line sample per tick and drives a fan output with hysteresis
// ----------------------------------------------------------------------------
// usage
//   s_* request: one sampled line level per tick (s_tdata bit 0), s_tuser
//     high starts a new frame on that sample and drops any running frame
//   m_* request: one result at the end of each frame, by timeout or after
//     the last phase; s_tuser-free samples outside a frame give nothing
//   cfg_*: register writes, always ready; write only while the block is idle (not enforced)
// throughput and result path
//   one sample accepted per cycle while s_tready is high; the sample state
//   (phase length, phase count, bit shift register) updates in the accepting
//   cycle; a result reaches m_tdata by way of the frame register, which holds
//   the finished frame, and the output register, with the decode and fan
//   compare in front of the output register
// reset
//   rst_n clears the frame state but for the bit shift register, clears the fan and loads the register defaults
// stall
//   while m_tready is low the result holds; one more finished frame can wait
//   in the frame register, after which s_tready drops
// ----------------------------------------------------------------------------
`include "single_wire_humidity_temp_receiver_top_defines.svh"

module single_wire_humidity_temp_receiver_top
#(
    parameter int MAX_PHASES = swhtr_pkg::MAX_PHASES_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    // sample stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [0] line_level, [7:1] zero
    input  logic        s_tuser,   // [0] frame_start
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [15:0] humidity_tenths, [31:16] temperature_tenths,
                                   // [37:32] bits_received, [38] fan_drive, [39] zero
    output logic        m_tuser,   // [0] data_good
    // configuration writes
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    localparam int NBITS = swhtr_pkg::BITS_PER_FRAME;

    // configuration registers
    logic [7:0]         thresh_reg;
    logic [7:0]         timeout_reg;
    logic signed [15:0] on_above_reg;
    logic signed [15:0] off_below_reg;

    // frame state
    logic             prev_level_reg, prev_level_next;
    logic [7:0]       phase_len_reg, phase_len_next;
    logic [6:0]       phase_num_reg, phase_num_next;
    logic [5:0]       bit_total_reg, bit_total_next;
    logic [NBITS-1:0] frame_bits_reg, frame_bits_next;
    logic             receiving_reg, receiving_next;
    logic             fan_reg, fan_next;

    // finished frame and output stages
    logic                pend_valid_reg, pend_valid_next;
    swhtr_pkg::frame_t   pend_reg;
    logic                out_valid_reg, out_valid_next;
    swhtr_pkg::result_t  out_reg;
    swhtr_pkg::result_t  dec_result;

    // sample view after a possible frame start
    logic       in_fire;
    logic       level;
    logic       recv;
    logic       prev_b;
    logic [7:0] len_b;
    logic [6:0] phase_b;
    logic [5:0] bits_b;
    logic       take_bit;
    logic       finish;
    logic       out_load;
    logic       pend_move;

    // handshakes
    assign out_load  = !out_valid_reg || m_tready;
    assign pend_move = pend_valid_reg && out_load;
    assign s_tready  = !pend_valid_reg || out_load;
    assign in_fire   = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    assign level   = s_tdata[0];
    assign recv    = s_tuser || receiving_reg;
    assign prev_b  = s_tuser ? 1'b1 : prev_level_reg;
    assign len_b   = s_tuser ? 8'd0 : phase_len_reg;
    assign phase_b = s_tuser ? 7'd0 : phase_num_reg;
    assign bits_b  = s_tuser ? 6'd0 : bit_total_reg;
    assign take_bit = (phase_b >= 7'(swhtr_pkg::FIRST_DATA_PHASE)) && !phase_b[0]
                      && (bits_b < 6'(NBITS));

    // per-sample phase tracking and bit capture
    always_comb
    begin
        prev_level_next = prev_level_reg;
        phase_len_next  = phase_len_reg;
        phase_num_next  = phase_num_reg;
        bit_total_next  = bit_total_reg;
        frame_bits_next = frame_bits_reg;
        receiving_next  = receiving_reg;
        finish          = 1'b0;
        if (in_fire && recv)
        begin
            receiving_next  = 1'b1;
            prev_level_next = prev_b;
            phase_num_next  = phase_b;
            bit_total_next  = bits_b;
            if (level == prev_b)
            begin
                phase_len_next = len_b + 8'd1;
                finish = (phase_len_next == timeout_reg);
            end
            else
            begin
                prev_level_next = level;
                if (take_bit)
                begin
                    frame_bits_next = {frame_bits_reg[NBITS-2:0], (len_b > thresh_reg)};
                    bit_total_next  = bits_b + 6'd1;
                end
                phase_len_next = 8'd0;
                phase_num_next = phase_b + 7'd1;
                finish = (phase_num_next >= 7'(MAX_PHASES));
            end
            if (finish)
            begin
                receiving_next = 1'b0;
            end
        end
    end

    // stage valids and fan update
    always_comb
    begin
        pend_valid_next = pend_valid_reg;
        if (finish)
        begin
            pend_valid_next = 1'b1;
        end
        else if (pend_move)
        begin
            pend_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (pend_move)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
        fan_next = pend_move ? dec_result.fan_drive : fan_reg;
    end

    // frame decode
    swhtr_decode u_decode
    (
        .frame         (pend_reg),
        .fan_on_above  (on_above_reg),
        .fan_off_below (off_below_reg),
        .fan_state     (fan_reg),
        .result        (dec_result)
    );

    // control state and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_level_reg <= 1'b1;
            phase_len_reg  <= 8'd0;
            phase_num_reg  <= 7'd0;
            bit_total_reg  <= 6'd0;
            receiving_reg  <= 1'b0;
            fan_reg        <= 1'b0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            thresh_reg     <= swhtr_pkg::THRESHOLD_RST;
            timeout_reg    <= swhtr_pkg::TIMEOUT_RST;
            on_above_reg   <= swhtr_pkg::FAN_ON_ABOVE_RST;
            off_below_reg  <= swhtr_pkg::FAN_OFF_BELOW_RST;
        end
        else
        begin
            prev_level_reg <= prev_level_next;
            phase_len_reg  <= phase_len_next;
            phase_num_reg  <= phase_num_next;
            bit_total_reg  <= bit_total_next;
            receiving_reg  <= receiving_next;
            fan_reg        <= fan_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    swhtr_pkg::CFG_ONE_BIT_THRESHOLD: thresh_reg    <= cfg_data[7:0];
                    swhtr_pkg::CFG_TIMEOUT_SAMPLES:   timeout_reg   <= cfg_data[7:0];
                    swhtr_pkg::CFG_FAN_ON_ABOVE:      on_above_reg  <= $signed(cfg_data);
                    swhtr_pkg::CFG_FAN_OFF_BELOW:     off_below_reg <= $signed(cfg_data);
                    default:                          thresh_reg    <= thresh_reg;
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        frame_bits_reg <= frame_bits_next;
        if (finish)
        begin
            pend_reg.bits  <= frame_bits_next;
            pend_reg.count <= bit_total_next;
        end
        if (pend_move)
        begin
            out_reg <= dec_result;
        end
    end

    // result stream
    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_reg.data_good;
    assign m_tdata  = {1'b0, out_reg.fan_drive, out_reg.bits_received,
                       out_reg.temperature_tenths, out_reg.humidity_tenths};

    // checks
    `SWHTR_ASSERT_IMP(a_bad_frame_zero, out_valid_reg && !out_reg.data_good,
        (out_reg.humidity_tenths == 16'd0) && (out_reg.temperature_tenths == 16'sd0),
        "bad frame carries nonzero readings")
    `SWHTR_ASSERT_IMP(a_bit_count_range, 1'b1, bit_total_reg <= 6'(NBITS),
        "bit count ran past a full frame")
    `SWHTR_ASSERT_NXT(a_fan_kept_on_bad, pend_move && !dec_result.data_good,
        $stable(fan_reg), "fan changed on a bad frame")

endmodule

### sim/tb_single_wire_humidity_temp_receiver_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_single_wire_humidity_temp_receiver_top
// drives sampled sensor line levels into the receiver as whole frames,
// broken frames and line noise, predicts every decoded result with a
// bit-accurate sensor frame predictor and checks each result field by field,
// under random stalls on both streams and several register settings
// ----------------------------------------------------------------------------
module tb_single_wire_humidity_temp_receiver_top;

    import swhtr_pkg::*;

    localparam int FULL_PHASES   = MAX_PHASES_DEF - 1;
    localparam int SETTLE_CYCLES = 8;
    localparam int HOLD_CYCLES   = 50;
    localparam int QUIET_LIMIT   = 5000;

    // how a generated frame is left behind
    typedef enum int {TAIL_NONE, TAIL_TIMEOUT, TAIL_EDGE} frame_tail_e;

    // frame decoder predictor and store of expected results
    class humidity_scoreboard;
        logic [7:0]         threshold;
        logic [7:0]         timeout;
        logic signed [15:0] fan_on_above;
        logic signed [15:0] fan_off_below;
        bit                 prev_level;
        logic [7:0]         phase_len;
        logic [6:0]         phase_num;
        logic [5:0]         bit_count;
        logic [7:0]         frame_byte [5];
        bit                 receiving;
        bit                 fan_on;
        result_t            expected_q [$];
        int                 errors;

        function new();
            threshold     = THRESHOLD_RST;
            timeout       = TIMEOUT_RST;
            fan_on_above  = FAN_ON_ABOVE_RST;
            fan_off_below = FAN_OFF_BELOW_RST;
            clear_frame();
            receiving     = 1'b0;
            fan_on        = 1'b0;
            errors        = 0;
        endfunction

        function void clear_frame();
            prev_level = 1'b1;
            phase_len  = '0;
            phase_num  = '0;
            bit_count  = '0;
            for (int i = 0; i < 5; i++)
                frame_byte[i] = '0;
        endfunction

        function void set_reg(logic [1:0] idx, logic [15:0] value);
            case (idx)
                CFG_ONE_BIT_THRESHOLD: threshold     = value[7:0];
                CFG_TIMEOUT_SAMPLES:   timeout       = value[7:0];
                CFG_FAN_ON_ABOVE:      fan_on_above  = value;
                CFG_FAN_OFF_BELOW:     fan_off_below = value;
                default: ;
            endcase
        endfunction

        // frame end: checksum, decode and fan hysteresis
        function void close_frame();
            logic [7:0]         byte_sum;
            logic signed [15:0] magnitude;
            logic signed [15:0] temp_tenths;
            result_t            r;
            byte_sum = frame_byte[0] + frame_byte[1] + frame_byte[2] + frame_byte[3];
            r = '0;
            r.data_good     = (bit_count >= BITS_PER_FRAME) && (frame_byte[4] == byte_sum);
            r.bits_received = bit_count;
            receiving = 1'b0;
            if (r.data_good)
            begin
                r.humidity_tenths = {frame_byte[0], frame_byte[1]};
                magnitude   = {1'b0, frame_byte[2][6:0], frame_byte[3]};
                temp_tenths = frame_byte[2][7] ? -magnitude : magnitude;
                r.temperature_tenths = temp_tenths;
                if (temp_tenths > fan_on_above)
                    fan_on = 1'b1;
                else if (temp_tenths < fan_off_below)
                    fan_on = 1'b0;
            end
            r.fan_drive = fan_on;
            expected_q.push_back(r);
        endfunction

        // one accepted line sample
        function void note_sample(bit lvl, bit start);
            if (start)
            begin
                clear_frame();
                receiving = 1'b1;
            end
            if (!receiving)
                return;
            if (lvl == prev_level)
            begin
                phase_len = phase_len + 8'd1;
                if (phase_len == timeout)
                    close_frame();
                return;
            end
            // edge: the old phase ends, even data phases deliver a bit
            prev_level = lvl;
            if (phase_num >= FIRST_DATA_PHASE && !phase_num[0] && bit_count < BITS_PER_FRAME)
            begin
                frame_byte[bit_count[5:3]] = {frame_byte[bit_count[5:3]][6:0],
                                              phase_len > threshold};
                bit_count++;
            end
            phase_len = '0;
            phase_num = phase_num + 7'd1;
            if (phase_num >= MAX_PHASES_DEF)
                close_frame();
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        task report(string msg);
            $display("ERROR at %0t ns: %s", $time, msg);
            errors++;
        endtask

        task check_result(logic [39:0] data, logic good_flag);
            result_t want;
            if (expected_q.size() == 0)
            begin
                report($sformatf("result with nothing expected, data %h", data));
                return;
            end
            want = expected_q.pop_front();
            if (data[15:0] !== want.humidity_tenths)
                report($sformatf("humidity %h, expected %h", data[15:0], want.humidity_tenths));
            if (data[31:16] !== want.temperature_tenths)
                report($sformatf("temperature %h, expected %h", data[31:16],
                                 want.temperature_tenths));
            if (good_flag !== want.data_good)
                report($sformatf("data_good %b, expected %b", good_flag, want.data_good));
            if (data[37:32] !== want.bits_received)
                report($sformatf("bits %0d, expected %0d", data[37:32], want.bits_received));
            if (data[38] !== want.fan_drive)
                report($sformatf("fan %b, expected %b", data[38], want.fan_drive));
        endtask
    endclass

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;
    logic        m_tuser;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [15:0] cfg_data;

    humidity_scoreboard sb;
    int send_idle_pct = 25;
    int recv_idle_pct = 86;
    bit hold_start    = 1'b0;
    int quiet_cycles  = 0;

    single_wire_humidity_temp_receiver_top #(
        .MAX_PHASES (MAX_PHASES_DEF)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // clock
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // result side: random stalls plus one long hold-off on request
    initial
    begin
        int hold_left;
        hold_left = 0;
        m_tready  = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_start)
            begin
                hold_left  = HOLD_CYCLES;
                hold_start = 1'b0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else
                m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // result check and watchdog
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
                sb.check_result(m_tdata, m_tuser);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    // one line sample request
    task automatic send_sample(bit lvl, bit start);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {7'd0, lvl};
        s_tuser  <= start;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        sb.note_sample(lvl, start);
        @(negedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [15:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        sb.set_reg(idx, value);
        @(negedge clk);
    endtask

    task automatic write_config(int thr, int tmo, int on_t, int off_t);
        write_reg(CFG_ONE_BIT_THRESHOLD, 16'(thr));
        write_reg(CFG_TIMEOUT_SAMPLES, 16'(tmo));
        write_reg(CFG_FAN_ON_ABOVE, 16'(on_t));
        write_reg(CFG_FAN_OFF_BELOW, 16'(off_t));
        cfg_valid <= 1'b0;
    endtask

    // close any open frame, then wait for every result to drain
    task automatic settle();
        while (sb.receiving)
            send_sample(sb.prev_level, 1'b0);
        s_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // longest phase length that stays clear of the timeout
    function automatic int phase_room();
        return (sb.timeout == 0) ? 255 : int'(sb.timeout) - 1;
    endfunction

    function automatic int filler_len(int hi);
        return int'($urandom_range(0, (hi < 1) ? hi : 1));
    endfunction

    // phase length that reads as the given bit, often right at the threshold
    function automatic int bit_len(bit b);
        int room;
        int lo;
        room = phase_room();
        if (!b)
        begin
            lo = (int'(sb.threshold) < room) ? int'(sb.threshold) : room;
            if ($urandom_range(0, 7) == 0)
                return lo;
            return int'($urandom_range(0, (lo < 3) ? lo : 3));
        end
        lo = int'(sb.threshold) + 1;
        if (lo > room)
            return room;
        return lo + int'($urandom_range(0, ((room - lo) < 2) ? room - lo : 2));
    endfunction

    // sensor frame: start, preamble phases, data phases, then the chosen ending
    task automatic send_frame(logic [39:0] payload, int phases, frame_tail_e tail);
        int room;
        int first_p;
        int len;
        int k;
        bit lvl;
        room = phase_room();
        lvl  = (room == 0) ? 1'b0 : ($urandom_range(0, 3) != 0);
        send_sample(lvl, 1'b1);
        if (lvl)
        begin
            repeat (filler_len(room - 1)) send_sample(1'b1, 1'b0);
            first_p = 1;
        end
        else
        begin
            repeat (filler_len(room)) send_sample(1'b0, 1'b0);
            first_p = 2;
        end
        for (int p = first_p; p <= phases; p++)
        begin
            lvl = (p % 2 == 0);
            k   = (p - FIRST_DATA_PHASE) / 2;
            if (p == phases && tail == TAIL_TIMEOUT)
                len = room + 1;
            else if (p >= FIRST_DATA_PHASE && p % 2 == 0 && k < BITS_PER_FRAME)
                len = bit_len(payload[39 - k]);
            else
                len = filler_len(room);
            send_sample(lvl, 1'b0);
            repeat (len) send_sample(lvl, 1'b0);
        end
        if (tail == TAIL_EDGE)
            send_sample(~lvl, 1'b0);
    endtask

    // random levels in runs, with the odd frame start
    task automatic line_noise(int count, int start_odds);
        bit lvl;
        bit start;
        lvl = 1'($urandom_range(0, 1));
        repeat (count)
        begin
            if ($urandom_range(0, 2) == 0)
                lvl = ~lvl;
            start = (start_odds != 0) && ($urandom_range(0, start_odds - 1) == 0);
            send_sample(lvl, start);
        end
    endtask

    // five frame bytes, temperature often near the fan thresholds
    function automatic logic [39:0] make_payload(bit sum_ok);
        int          t;
        logic [15:0] hum;
        logic [15:0] temp_code;
        logic [7:0]  check;
        hum = 16'($urandom);
        case ($urandom_range(0, 4))
            0:       t = int'($urandom_range(0, 65534)) - 32767;
            1:       t = sb.fan_on_above + 1 - int'($urandom_range(0, 2));
            2:       t = sb.fan_off_below - 1 + int'($urandom_range(0, 2));
            3:       t = (sb.fan_on_above + sb.fan_off_below) / 2;
            default: t = 0;
        endcase
        if (t > 32767)
            t = 32767;
        if (t < -32767)
            t = -32767;
        temp_code = (t < 0) ? {1'b1, 15'(-t)} : {1'b0, 15'(t)};
        if (t == 0 && $urandom_range(0, 1) == 1)
            temp_code = 16'h8000;
        check = hum[15:8] + hum[7:0] + temp_code[15:8] + temp_code[7:0];
        if (!sum_ok)
            check = check ^ 8'($urandom_range(1, 255));
        return {hum, temp_code, check};
    endfunction

    // stimulus
    initial
    begin
        int thr;
        int tmo;
        int on_t;
        int off_t;
        sb        = new();
        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // register defaults: samples outside a frame
        line_noise(6, 0);

        // short phases: a frame dropped by a new start, then an early end
        settle();
        write_config(0, 3, 200, 150);
        send_frame(make_payload(1'b1), 6, TAIL_NONE);
        send_frame(make_payload(1'b1), 9, TAIL_TIMEOUT);

        // shortest timeout
        settle();
        write_config(0, 1, 200, 150);
        line_noise(16, 3);

        // full frames under three stall patterns
        for (int mode = 0; mode < 3; mode++)
        begin
            settle();
            case (mode)
                0:
                begin
                    send_idle_pct = 25;
                    recv_idle_pct = 86;
                end
                1:
                begin
                    send_idle_pct = 86;
                    recv_idle_pct = 25;
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            thr   = $urandom_range(0, 1);
            tmo   = thr + int'($urandom_range(2, 3));
            on_t  = int'($urandom_range(0, 600)) - 300;
            off_t = on_t - int'($urandom_range(0, 80));
            if (mode == 2)
            begin
                // hold off results while frames keep ending, so the input stalls
                write_config(0, 1, on_t, off_t);
                hold_start = 1'b1;
                line_noise(HOLD_CYCLES + 20, 3);
                settle();
            end
            write_config(thr, tmo, on_t, off_t);
            case (mode)
                0:       send_frame({8'h00, 8'h00, 8'h80, 8'h00, 8'h80}, FULL_PHASES, TAIL_EDGE);
                1:       send_frame(make_payload(1'b1), FULL_PHASES - 1, TAIL_TIMEOUT);
                default: send_frame(make_payload(1'b0), FULL_PHASES, TAIL_EDGE);
            endcase
        end

        settle();
        if (sb.pending() != 0)
            sb.report($sformatf("%0d results never arrived", sb.pending()));
        if (sb.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
